[rtl/core/process_table_ready_queue_core_macros.svh]
// Assertion macros shared by the process table core RTL.
// Clocked on i_clk, disabled while i_rst_n is low; include in module bodies only.
`ifndef PROCESS_TABLE_READY_QUEUE_CORE_MACROS_SVH
`define PROCESS_TABLE_READY_QUEUE_CORE_MACROS_SVH

// Condition holds at every clock edge out of reset.
`define PTQR_ASSERT_ALWAYS(lbl, cond) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) \
        else $error("ptqr assertion failed");

// Consequent holds in the same cycle as the antecedent.
`define PTQR_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptqr assertion failed");

// Consequent holds in the cycle after the antecedent.
`define PTQR_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptqr assertion failed");

`endif

[rtl/core/ptqr_pkg.sv]
// Package for the process table / ready queue core.
// Sizes, derived widths, operation and status codes, shared struct types. No dependencies.
`default_nettype none

package ptqr_pkg;

    localparam int TABLE_SIZE  = 8;
    localparam int QUEUE_DEPTH = 16;
    localparam int ID_BITS     = 8;
    localparam int PRIO_W      = 8;
    localparam int STATUS_W    = 3;
    localparam int MODE_W      = 2;

    localparam int TIDX_W = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int TCNT_W = $clog2(TABLE_SIZE + 1);
    localparam int QIDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W  = (TCNT_W > QCNT_W) ? TCNT_W : QCNT_W;

    localparam logic [MODE_W-1:0] MODE_CREATE  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_DELETE  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BLOCK   = 2'd2;
    localparam logic [MODE_W-1:0] MODE_UNBLOCK = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_TABLE_FULL  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_QUEUE_EMPTY = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 3'd3;
    localparam logic [STATUS_W-1:0] ST_QUEUE_FULL  = 3'd4;

    typedef struct packed {
        logic [ID_BITS-1:0] id;
        logic [PRIO_W-1:0]  pri;
        logic               blk;
    } t_entry;

    typedef struct packed {
        logic              en;
        logic [TIDX_W-1:0] idx;
        t_entry            entry;
    } t_tbl_wr;

    typedef struct packed {
        logic               en;
        logic [QIDX_W-1:0]  idx;
        logic [ID_BITS-1:0] id;
    } t_q_wr;

    typedef struct packed {
        logic inc;
        logic dec;
    } t_cnt_op;

    typedef struct packed {
        logic hit;
        logic idx_lt;
        logic inc_lt;
    } t_cmp_res;

endpackage

`default_nettype wire

[rtl/core/ptqr_table.sv]
// Process table storage: entries of id, priority and blocked bit, plus fill count.
// One read port, one write port. Depends on ptqr_pkg.
`default_nettype none

module ptqr_table (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ptqr_pkg::TIDX_W-1:0] i_rd_idx,
    output ptqr_pkg::t_entry                 o_rd_entry,
    input  wire ptqr_pkg::t_tbl_wr           i_wr,
    input  wire ptqr_pkg::t_cnt_op           i_cnt_op,
    output logic [ptqr_pkg::TCNT_W-1:0]      o_count
);
    import ptqr_pkg::*;

    t_entry              r_mem [TABLE_SIZE];
    logic [TCNT_W-1:0]   r_count;

    // contents need no reset: only entries below the count are ever read
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cnt_op.inc) begin
            r_count <= r_count + TCNT_W'(1);
        end else if (i_cnt_op.dec) begin
            r_count <= r_count - TCNT_W'(1);
        end
    end

    assign o_rd_entry = r_mem[i_rd_idx];
    assign o_count    = r_count;

endmodule

`default_nettype wire

[rtl/core/ptqr_queue.sv]
// Ready queue storage: ids ordered head first at slot zero, plus fill count.
// One read port, one write port. Depends on ptqr_pkg.
`default_nettype none

module ptqr_queue (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic [ptqr_pkg::QIDX_W-1:0] i_rd_idx,
    output logic [ptqr_pkg::ID_BITS-1:0]     o_rd_id,
    input  wire ptqr_pkg::t_q_wr             i_wr,
    input  wire ptqr_pkg::t_cnt_op           i_cnt_op,
    output logic [ptqr_pkg::QCNT_W-1:0]      o_count
);
    import ptqr_pkg::*;

    logic [ID_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [QCNT_W-1:0]  r_count;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= i_wr.id;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cnt_op.inc) begin
            r_count <= r_count + QCNT_W'(1);
        end else if (i_cnt_op.dec) begin
            r_count <= r_count - QCNT_W'(1);
        end
    end

    assign o_rd_id = r_mem[i_rd_idx];
    assign o_count = r_count;

endmodule

`default_nettype wire

[rtl/core/ptqr_cmp.sv]
// Shared compare unit: id match and walk-index bound checks against the table or queue.
// Combinational. Depends on ptqr_pkg.
`default_nettype none

module ptqr_cmp (
    input  wire logic                         i_sel_q,
    input  wire logic [ptqr_pkg::ID_BITS-1:0] i_key,
    input  wire logic [ptqr_pkg::ID_BITS-1:0] i_t_id,
    input  wire logic [ptqr_pkg::ID_BITS-1:0] i_q_id,
    input  wire logic [ptqr_pkg::TCNT_W-1:0]  i_t_count,
    input  wire logic [ptqr_pkg::QCNT_W-1:0]  i_q_count,
    input  wire logic [ptqr_pkg::IDX_W-1:0]   i_idx,
    input  wire logic [ptqr_pkg::IDX_W:0]     i_idx_inc,
    output ptqr_pkg::t_cmp_res                o_res
);
    import ptqr_pkg::*;

    logic [ID_BITS-1:0] w_data;
    logic [IDX_W-1:0]   w_count;

    // steer the one comparator to the store being walked
    assign w_data  = i_sel_q ? i_q_id : i_t_id;
    assign w_count = i_sel_q ? IDX_W'(i_q_count) : IDX_W'(i_t_count);

    assign o_res.hit    = (w_data == i_key);
    assign o_res.idx_lt = (i_idx < w_count);
    assign o_res.inc_lt = (i_idx_inc < (IDX_W + 1)'(w_count));

endmodule

`default_nettype wire

[rtl/core/process_table_ready_queue_core.sv]
// Process table / ready queue core: top level with the operation sequencer.
// Depends on ptqr_pkg, ptqr_table, ptqr_queue, ptqr_cmp and the assertion macro header.
//
// Input channel (i_in_valid / o_in_stall) carries one operation item: mode, process id,
// priority and initial blocked flag. Output channel (o_out_valid / i_out_stall) returns
// exactly one result item per operation: status, id, priority, blocked flag and the
// table and queue fill counts after the operation.
// One item at a time: o_in_stall stays high from acceptance until its result is taken.
// A single walk index steps through the table or the queue one entry per cycle with one
// shared id comparator. Create writes both stores directly; delete on an empty queue ends
// directly, else it takes the head id, shifts the queue up, then finds and shifts out the
// table entry; block walks the whole table, then, for a known id, finds and drops the
// first queued copy; unblock walks the whole table and then enqueues a known id.
// Reset (i_rst_n low, synchronous) clears both fill counts and the sequencer; table and
// queue contents are not cleared, only entries below the counts are ever read.
// While i_out_stall is high the result item holds on the output registers and no new
// item is accepted.
`default_nettype none

module process_table_ready_queue_core (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire logic [ptqr_pkg::MODE_W-1:0]   i_mode,
    input  wire logic [7:0]                    i_process_id,
    input  wire logic [7:0]                    i_priority_req,
    input  wire logic                          i_initial_blocked,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output logic [ptqr_pkg::STATUS_W-1:0]      o_status,
    output logic [7:0]                         o_out_id,
    output logic [7:0]                         o_out_priority,
    output logic                               o_out_blocked,
    output logic [3:0]                         o_table_count,
    output logic [4:0]                         o_queue_count
);
    import ptqr_pkg::*;

    `include "process_table_ready_queue_core_macros.svh"

    // sequencer states
    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_START  = 4'd1;
    localparam logic [3:0] S_QSHIFT = 4'd2;
    localparam logic [3:0] S_TFIND  = 4'd3;
    localparam logic [3:0] S_TSHIFT = 4'd4;
    localparam logic [3:0] S_TWALK  = 4'd5;
    localparam logic [3:0] S_QFIND  = 4'd6;
    localparam logic [3:0] S_DONE   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    logic [3:0]          r_state,  n_state;
    logic [MODE_W-1:0]   r_mode,   n_mode;
    logic [ID_BITS-1:0]  r_key,    n_key;
    logic [PRIO_W-1:0]   r_prio,   n_prio;
    logic                r_ib,     n_ib;
    logic [IDX_W-1:0]    r_idx,    n_idx;
    logic                r_found,  n_found;
    logic                r_qfull,  n_qfull;
    logic [STATUS_W-1:0] r_status, n_status;
    logic [ID_BITS-1:0]  r_oid,    n_oid;
    logic [PRIO_W-1:0]   r_opri,   n_opri;
    logic                r_oblk,   n_oblk;

    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [7:0]          r_out_id,     n_out_id;
    logic [7:0]          r_out_pri,    n_out_pri;
    logic                r_out_blk,    n_out_blk;
    logic [3:0]          r_out_tcnt,   n_out_tcnt;
    logic [4:0]          r_out_qcnt,   n_out_qcnt;

    logic [IDX_W:0]      w_idx_inc;
    logic [TIDX_W-1:0]   w_t_rd_idx;
    logic [QIDX_W-1:0]   w_q_rd_idx;
    t_entry              w_t_rd;
    t_entry              w_t_upd;
    logic [ID_BITS-1:0]  w_q_rd;
    t_tbl_wr             w_t_wr;
    t_q_wr               w_q_wr;
    t_cnt_op             w_t_op;
    t_cnt_op             w_q_op;
    logic [TCNT_W-1:0]   w_t_count;
    logic [QCNT_W-1:0]   w_q_count;
    logic                w_sel_q;
    t_cmp_res            w_cmp;
    logic                w_t_full;
    logic                w_q_full;

    ptqr_table u_table (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_rd_idx   (w_t_rd_idx),
        .o_rd_entry (w_t_rd),
        .i_wr       (w_t_wr),
        .i_cnt_op   (w_t_op),
        .o_count    (w_t_count)
    );

    ptqr_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_idx (w_q_rd_idx),
        .o_rd_id  (w_q_rd),
        .i_wr     (w_q_wr),
        .i_cnt_op (w_q_op),
        .o_count  (w_q_count)
    );

    ptqr_cmp u_cmp (
        .i_sel_q   (w_sel_q),
        .i_key     (r_key),
        .i_t_id    (w_t_rd.id),
        .i_q_id    (w_q_rd),
        .i_t_count (w_t_count),
        .i_q_count (w_q_count),
        .i_idx     (r_idx),
        .i_idx_inc (w_idx_inc),
        .o_res     (w_cmp)
    );

    assign w_idx_inc = (IDX_W + 1)'(r_idx) + (IDX_W + 1)'(1);
    assign w_sel_q   = (r_state == S_QSHIFT) || (r_state == S_QFIND);
    assign w_t_full  = (w_t_count >= TCNT_W'(TABLE_SIZE));
    assign w_q_full  = (w_q_count >= QCNT_W'(QUEUE_DEPTH));

    // shift passes read one slot ahead of the slot they write
    assign w_t_rd_idx = (r_state == S_TSHIFT) ? w_idx_inc[TIDX_W-1:0] : r_idx[TIDX_W-1:0];
    assign w_q_rd_idx = (r_state == S_QSHIFT) ? w_idx_inc[QIDX_W-1:0] : r_idx[QIDX_W-1:0];

    // walk write-back: same entry with the blocked bit forced by the operation
    always_comb begin
        w_t_upd     = w_t_rd;
        w_t_upd.blk = (r_mode == MODE_BLOCK);
    end

    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_key        = r_key;
        n_prio       = r_prio;
        n_ib         = r_ib;
        n_idx        = r_idx;
        n_found      = r_found;
        n_qfull      = r_qfull;
        n_status     = r_status;
        n_oid        = r_oid;
        n_opri       = r_opri;
        n_oblk       = r_oblk;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_id     = r_out_id;
        n_out_pri    = r_out_pri;
        n_out_blk    = r_out_blk;
        n_out_tcnt   = r_out_tcnt;
        n_out_qcnt   = r_out_qcnt;
        w_t_wr       = '0;
        w_q_wr       = '0;
        w_t_op       = '0;
        w_q_op       = '0;

        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_mode  = i_mode;
                    n_key   = ID_BITS'(i_process_id);
                    n_prio  = i_priority_req;
                    n_ib    = i_initial_blocked;
                    n_idx   = '0;
                    n_state = S_START;
                end
            end

            S_START: begin
                n_status = ST_OK;
                n_oid    = r_key;
                n_opri   = '0;
                n_oblk   = 1'b0;
                n_found  = 1'b0;
                n_qfull  = w_q_full;
                case (r_mode)
                    MODE_CREATE: begin
                        // echo the request whether or not it is taken
                        n_opri  = r_prio;
                        n_oblk  = r_ib;
                        n_state = S_DONE;
                        if (w_t_full) begin
                            n_status = ST_TABLE_FULL;
                        end else if (w_q_full) begin
                            n_status = ST_QUEUE_FULL;
                        end else begin
                            w_t_wr.en        = 1'b1;
                            w_t_wr.idx       = w_t_count[TIDX_W-1:0];
                            w_t_wr.entry.id  = r_key;
                            w_t_wr.entry.pri = r_prio;
                            w_t_wr.entry.blk = r_ib;
                            w_t_op.inc       = 1'b1;
                            w_q_wr.en        = 1'b1;
                            w_q_wr.idx       = w_q_count[QIDX_W-1:0];
                            w_q_wr.id        = r_key;
                            w_q_op.inc       = 1'b1;
                        end
                    end
                    MODE_DELETE: begin
                        if (w_q_count == '0) begin
                            n_status = ST_QUEUE_EMPTY;
                            n_oid    = '0;
                            n_state  = S_DONE;
                        end else begin
                            // take the head id, then close the gap it leaves
                            n_key   = w_q_rd;
                            n_oid   = w_q_rd;
                            n_state = S_QSHIFT;
                        end
                    end
                    default: begin
                        n_state = S_TWALK;
                    end
                endcase
            end

            S_QSHIFT: begin
                if (w_cmp.inc_lt) begin
                    w_q_wr.en  = 1'b1;
                    w_q_wr.idx = r_idx[QIDX_W-1:0];
                    w_q_wr.id  = w_q_rd;
                    n_idx      = w_idx_inc[IDX_W-1:0];
                end else begin
                    w_q_op.dec = 1'b1;
                    n_idx      = '0;
                    n_state    = (r_mode == MODE_DELETE) ? S_TFIND : S_DONE;
                end
            end

            S_TFIND: begin
                if (w_cmp.idx_lt) begin
                    if (w_cmp.hit) begin
                        n_opri  = w_t_rd.pri;
                        n_oblk  = w_t_rd.blk;
                        n_state = S_TSHIFT;
                    end else begin
                        n_idx = w_idx_inc[IDX_W-1:0];
                    end
                end else begin
                    // head id had no table entry: it stays dequeued
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end
            end

            S_TSHIFT: begin
                if (w_cmp.inc_lt) begin
                    w_t_wr.en    = 1'b1;
                    w_t_wr.idx   = r_idx[TIDX_W-1:0];
                    w_t_wr.entry = w_t_rd;
                    n_idx        = w_idx_inc[IDX_W-1:0];
                end else begin
                    w_t_op.dec = 1'b1;
                    n_state    = S_DONE;
                end
            end

            S_TWALK: begin
                if (w_cmp.idx_lt) begin
                    if (w_cmp.hit) begin
                        if (!r_found) begin
                            n_found = 1'b1;
                            n_opri  = w_t_rd.pri;
                            n_oblk  = w_t_rd.blk;
                        end
                        // an unblock that cannot enqueue leaves every bit alone
                        if (!((r_mode == MODE_UNBLOCK) && r_qfull)) begin
                            w_t_wr.en    = 1'b1;
                            w_t_wr.idx   = r_idx[TIDX_W-1:0];
                            w_t_wr.entry = w_t_upd;
                        end
                    end
                    n_idx = w_idx_inc[IDX_W-1:0];
                end else if (!r_found) begin
                    n_status = ST_NOT_FOUND;
                    n_state  = S_DONE;
                end else if (r_mode == MODE_BLOCK) begin
                    n_oblk  = 1'b1;
                    n_idx   = '0;
                    n_state = S_QFIND;
                end else if (r_qfull) begin
                    n_status = ST_QUEUE_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_oblk     = 1'b0;
                    w_q_wr.en  = 1'b1;
                    w_q_wr.idx = w_q_count[QIDX_W-1:0];
                    w_q_wr.id  = r_key;
                    w_q_op.inc = 1'b1;
                    n_state    = S_DONE;
                end
            end

            S_QFIND: begin
                if (w_cmp.idx_lt) begin
                    if (w_cmp.hit) begin
                        // drop the first queued copy from this slot on
                        n_state = S_QSHIFT;
                    end else begin
                        n_idx = w_idx_inc[IDX_W-1:0];
                    end
                end else begin
                    n_state = S_DONE;
                end
            end

            S_DONE: begin
                n_out_valid  = 1'b1;
                n_out_status = r_status;
                n_out_id     = 8'(r_oid);
                n_out_pri    = r_opri;
                n_out_blk    = r_oblk;
                n_out_tcnt   = 4'(w_t_count);
                n_out_qcnt   = 5'(w_q_count);
                n_state      = S_OUT;
            end

            S_OUT: begin
                if (!i_out_stall) begin
                    n_out_valid = 1'b0;
                    n_state     = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_key        <= n_key;
        r_prio       <= n_prio;
        r_ib         <= n_ib;
        r_idx        <= n_idx;
        r_found      <= n_found;
        r_qfull      <= n_qfull;
        r_status     <= n_status;
        r_oid        <= n_oid;
        r_opri       <= n_opri;
        r_oblk       <= n_oblk;
        r_out_status <= n_out_status;
        r_out_id     <= n_out_id;
        r_out_pri    <= n_out_pri;
        r_out_blk    <= n_out_blk;
        r_out_tcnt   <= n_out_tcnt;
        r_out_qcnt   <= n_out_qcnt;
    end

    assign o_in_stall     = (r_state != S_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_status       = r_out_status;
    assign o_out_id       = r_out_id;
    assign o_out_priority = r_out_pri;
    assign o_out_blocked  = r_out_blk;
    assign o_table_count  = r_out_tcnt;
    assign o_queue_count  = r_out_qcnt;

    `PTQR_ASSERT_ALWAYS(a_tcnt_max, w_t_count <= TCNT_W'(TABLE_SIZE))
    `PTQR_ASSERT_ALWAYS(a_qcnt_max, w_q_count <= QCNT_W'(QUEUE_DEPTH))
    `PTQR_ASSERT_IMPL(a_result_blocks_input, o_out_valid, o_in_stall)
    `PTQR_ASSERT_NEXT(a_done_gives_result, r_state == S_DONE, o_out_valid)

endmodule

`default_nettype wire

[test/process_table_ready_queue_core_test.sv]
// Self-checking bench for process_table_ready_queue_core: directed and random operation items.
// Depends on ptqr_pkg and the core RTL; a scoreboard class predicts every result in order.
`timescale 1ns / 1ps

module process_table_ready_queue_core_test;
    import ptqr_pkg::*;

    // One result item as it leaves the block.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [7:0]          id;
        logic [7:0]          pri;
        logic                blk;
        logic [3:0]          tcnt;
        logic [4:0]          qcnt;
    } t_proc_result;

    // Shadow copy of the process table and ready queue, plus the results still owed.
    class proc_scoreboard;
        t_entry       table_q[$];
        logic [7:0]   ready_q[$];
        t_proc_result owed_q[$];
        int           errors;

        // Index of the first table entry with this id, or -1.
        function int first_entry(logic [7:0] pid);
            foreach (table_q[i])
                if (table_q[i].id == pid)
                    return i;
            return -1;
        endfunction

        // Duplicate ids all take the new blocked bit.
        function void mark_blocked(logic [7:0] pid, logic b);
            foreach (table_q[i])
                if (table_q[i].id == pid)
                    table_q[i].blk = b;
        endfunction

        function void note_item(logic [MODE_W-1:0] op, logic [7:0] pid, logic [7:0] pri,
                                logic ib);
            t_proc_result r;
            t_entry       e;
            int           k;
            int           j;
            r = '0;
            r.status = ST_OK;
            case (op)
                MODE_CREATE: begin
                    r.id = pid;
                    r.pri = pri;
                    r.blk = ib;
                    if (table_q.size() >= TABLE_SIZE) begin
                        r.status = ST_TABLE_FULL;
                    end else if (ready_q.size() >= QUEUE_DEPTH) begin
                        r.status = ST_QUEUE_FULL;
                    end else begin
                        e.id = pid;
                        e.pri = pri;
                        e.blk = ib;
                        table_q.push_back(e);
                        ready_q.push_back(pid);
                    end
                end
                MODE_DELETE: begin
                    if (ready_q.size() == 0) begin
                        r.status = ST_QUEUE_EMPTY;
                    end else begin
                        r.id = ready_q.pop_front();
                        k = first_entry(r.id);
                        if (k < 0) begin
                            r.status = ST_NOT_FOUND;
                        end else begin
                            r.pri = table_q[k].pri;
                            r.blk = table_q[k].blk;
                            table_q.delete(k);
                        end
                    end
                end
                MODE_BLOCK: begin
                    r.id = pid;
                    k = first_entry(pid);
                    if (k < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        mark_blocked(pid, 1'b1);
                        r.pri = table_q[k].pri;
                        r.blk = 1'b1;
                        // drop only the oldest queued copy, if any
                        for (j = 0; j < ready_q.size(); j++) begin
                            if (ready_q[j] == pid) begin
                                ready_q.delete(j);
                                break;
                            end
                        end
                    end
                end
                default: begin
                    r.id = pid;
                    k = first_entry(pid);
                    if (k < 0) begin
                        r.status = ST_NOT_FOUND;
                    end else begin
                        r.pri = table_q[k].pri;
                        if (ready_q.size() >= QUEUE_DEPTH) begin
                            r.status = ST_QUEUE_FULL;
                            r.blk = table_q[k].blk;
                        end else begin
                            mark_blocked(pid, 1'b0);
                            ready_q.push_back(pid);
                        end
                    end
                end
            endcase
            r.tcnt = 4'(table_q.size());
            r.qcnt = 5'(ready_q.size());
            owed_q.push_back(r);
        endfunction

        function void compare_field(string name, int unsigned want, int unsigned got);
            if (want != got) begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            end
        endfunction

        function void check_result(t_proc_result got);
            t_proc_result want;
            if (owed_q.size() == 0) begin
                errors++;
                $display("%0t: result item with nothing owed, expected none, got status %0d id %0d",
                         $time, got.status, got.id);
                return;
            end
            want = owed_q.pop_front();
            compare_field("status", want.status, got.status);
            compare_field("out_id", want.id, got.id);
            compare_field("out_priority", want.pri, got.pri);
            compare_field("out_blocked", want.blk, got.blk);
            compare_field("table_count", want.tcnt, got.tcnt);
            compare_field("queue_count", want.qcnt, got.qcnt);
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [MODE_W-1:0]    i_mode = MODE_CREATE;
    logic [7:0]           i_process_id = 8'h00;
    logic [7:0]           i_priority_req = 8'h00;
    logic                 i_initial_blocked = 1'b0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [STATUS_W-1:0]  o_status;
    logic [7:0]           o_out_id;
    logic [7:0]           o_out_priority;
    logic                 o_out_blocked;
    logic [3:0]           o_table_count;
    logic [4:0]           o_queue_count;

    proc_scoreboard sb;

    // Phases with no idling on one side or both; set by the stimulus process.
    bit tx_quiet;
    bit rx_quiet;

    process_table_ready_queue_core dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_mode            (i_mode),
        .i_process_id      (i_process_id),
        .i_priority_req    (i_priority_req),
        .i_initial_blocked (i_initial_blocked),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_status          (o_status),
        .o_out_id          (o_out_id),
        .o_out_priority    (o_out_priority),
        .o_out_blocked     (o_out_blocked),
        .o_table_count     (o_table_count),
        .o_queue_count     (o_queue_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Hard stop in case the block hangs; well beyond the slowest correct run.
    initial begin
        #10_000_000;
        $display("process_table_ready_queue_core_test failed");
        $finish;
    end

    // Offer one operation item and hold it until the block takes it. Note the item
    // with the scoreboard at the accepting edge, then idle for a drawn number of
    // cycles. Valid stays high into the next item when no gap is drawn.
    task automatic offer_item(input logic [MODE_W-1:0] op, input logic [7:0] pid,
                              input logic [7:0] pri, input logic ib);
        int gap;
        i_in_valid <= 1'b1;
        i_mode <= op;
        i_process_id <= pid;
        i_priority_req <= pri;
        i_initial_blocked <= ib;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_item(op, pid, pri, ib);
        gap = tx_quiet ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Random operation. Ids mostly come from a small pool so that creates, blocks,
    // unblocks and deletes keep hitting the same processes; a grow phase fills the
    // table and queue, a shrink phase empties them.
    task automatic offer_random(input bit grow);
        int                pick;
        logic [MODE_W-1:0] op;
        logic [7:0]        pid;
        pick = $urandom_range(0, 99);
        if (grow)
            op = (pick < 40) ? MODE_CREATE : (pick < 70) ? MODE_UNBLOCK :
                 (pick < 85) ? MODE_BLOCK : MODE_DELETE;
        else
            op = (pick < 15) ? MODE_CREATE : (pick < 30) ? MODE_UNBLOCK :
                 (pick < 50) ? MODE_BLOCK : MODE_DELETE;
        pick = $urandom_range(0, 99);
        if (pick < 75)
            pid = 8'($urandom_range(0, 9));
        else if (pick < 85)
            pid = pick[0] ? 8'hFF : 8'h00;
        else
            pid = 8'($urandom_range(0, 255));
        offer_item(op, pid, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    endtask

    // Drop valid and hold off until every owed result has come back.
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (sb.owed_q.size() != 0)
            @(posedge i_clk);
    endtask

    // Result side: stall for a drawn number of cycles before each result, then take
    // it and check it. Twice in the run, hold off for a long stretch so the block
    // backs up and stalls the sender.
    initial begin : result_sink
        int           gap;
        int           taken;
        t_proc_result got;
        taken = 0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (taken == 300 || taken == 1000)
                gap = 400;
            else
                gap = rx_quiet ? 0 : $urandom_range(0, 19);
            if (gap > 0) begin
                i_out_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            got.status = o_status;
            got.id = o_out_id;
            got.pri = o_out_priority;
            got.blk = o_out_blocked;
            got.tcnt = o_table_count;
            got.qcnt = o_queue_count;
            sb.check_result(got);
            taken++;
        end
    end

    initial begin : stimulus
        int i;
        int phase;
        sb = new();
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty queue, unknown ids, extreme fields.
        offer_item(MODE_DELETE, 8'h00, 8'h00, 1'b0);
        offer_item(MODE_BLOCK, 8'hFF, 8'hFF, 1'b1);
        offer_item(MODE_UNBLOCK, 8'h00, 8'h00, 1'b0);
        offer_item(MODE_CREATE, 8'h00, 8'h00, 1'b0);
        // created blocked, still enqueued
        offer_item(MODE_CREATE, 8'hFF, 8'hFF, 1'b1);
        // duplicate id
        offer_item(MODE_CREATE, 8'h00, 8'h5A, 1'b1);
        offer_item(MODE_CREATE, 8'hA5, 8'hA5, 1'b0);
        // block a duplicate twice, then once more when it is no longer queued
        offer_item(MODE_BLOCK, 8'h00, 8'h00, 1'b0);
        offer_item(MODE_BLOCK, 8'h00, 8'h00, 1'b0);
        offer_item(MODE_BLOCK, 8'h00, 8'h00, 1'b0);
        // unblock of a ready process queues it a second time
        offer_item(MODE_UNBLOCK, 8'hFF, 8'h00, 1'b0);
        for (i = 1; i <= 4; i++)
            offer_item(MODE_CREATE, i[7:0], 8'h80 | i[7:0], 1'b0);
        // table full
        offer_item(MODE_CREATE, 8'h07, 8'h07, 1'b1);
        // fill the queue, then unblock into a full queue
        for (i = 0; i < 9; i++)
            offer_item(MODE_UNBLOCK, 8'h00, 8'h00, 1'b0);
        offer_item(MODE_UNBLOCK, 8'h01, 8'h00, 1'b0);
        // free a table slot, refill the queue, then create into a full queue
        offer_item(MODE_DELETE, 8'h00, 8'h00, 1'b0);
        offer_item(MODE_UNBLOCK, 8'h00, 8'h00, 1'b0);
        offer_item(MODE_CREATE, 8'h33, 8'hCC, 1'b0);
        // second copy of the same head id: its table entry is already gone
        offer_item(MODE_DELETE, 8'h00, 8'h00, 1'b0);
        offer_item(MODE_DELETE, 8'h00, 8'h00, 1'b0);

        // Random: alternate grow and shrink phases, vary which side idles, and
        // pause the sender until drained now and then.
        for (phase = 0; phase < 16; phase++) begin
            tx_quiet = (phase % 4 == 1) || (phase % 4 == 3);
            rx_quiet = (phase % 4 == 1) || (phase % 4 == 2);
            if (phase == 5 || phase == 11)
                wait_drained();
            repeat (100) offer_random(phase % 2 == 0);
        end

        wait_drained();
        // let any stray result show up before the verdict
        repeat (40) @(posedge i_clk);
        if (sb.errors == 0)
            $display("process_table_ready_queue_core_test passed");
        else
            $display("process_table_ready_queue_core_test failed");
        $finish;
    end

endmodule

[process_table_ready_queue_core.f]
+incdir+rtl/core
rtl/core/ptqr_pkg.sv
rtl/core/ptqr_table.sv
rtl/core/ptqr_queue.sv
rtl/core/ptqr_cmp.sv
rtl/core/process_table_ready_queue_core.sv
test/process_table_ready_queue_core_test.sv
